>>> src/ptts_pkg.sv
package ptts_pkg;

	localparam int MAX_TASKS = 16;
	localparam int TIME_BITS = 16;
	localparam int JOB_W     = 16;
	localparam int SLOT_W    = $clog2(MAX_TASKS);
	localparam int CNT_W     = $clog2(MAX_TASKS + 1);
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic MODE_EDF = 1'b0;
	localparam logic MODE_RMS = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SCHED_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT = 1'd1;

	typedef struct packed {
		logic [TIME_BITS-1:0] budget_tab;
		logic [TIME_BITS-1:0] period_tab;
		logic [TIME_BITS-1:0] budget_left;
		logic [TIME_BITS-1:0] deadline_left;
		logic [JOB_W-1:0]     job_count;
	} entry_t;

	typedef struct packed {
		logic [SLOT_W-1:0] ran_slot;
		logic              idle;
		logic [JOB_W-1:0]  job_number;
		logic              job_done;
	} result_t;

endpackage

>>> src/ptts_task_ram.sv
module ptts_task_ram (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ptts_pkg::SLOT_W-1:0] waddr,
	input  ptts_pkg::entry_t            wdata,
	input  logic [ptts_pkg::SLOT_W-1:0] raddr,
	output ptts_pkg::entry_t            rdata
);

	ptts_pkg::entry_t mem [ptts_pkg::MAX_TASKS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> src/ptts_engine.sv
module ptts_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           func,
	input  logic [ptts_pkg::SLOT_W-1:0]    slot,
	input  logic [ptts_pkg::TIME_BITS-1:0] budget,
	input  logic [ptts_pkg::TIME_BITS-1:0] period_len,
	input  logic                           mode,
	input  logic [ptts_pkg::CNT_W-1:0]     n_live,
	input  logic                           out_free,
	output logic                           res_valid,
	output ptts_pkg::result_t              res
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_CDWN = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]                     state_q;
	logic [ptts_pkg::CNT_W-1:0]     issue_q;
	logic                           vld_s1;
	logic [ptts_pkg::SLOT_W-1:0]    idx_s1;
	logic                           found_q;
	logic [ptts_pkg::SLOT_W-1:0]    pick_q;
	logic [ptts_pkg::TIME_BITS-1:0] best_q;
	logic [ptts_pkg::JOB_W-1:0]     jobn_q;
	logic                           done_q;
	logic                           cur_valid_q;
	logic [ptts_pkg::SLOT_W-1:0]    cur_q;
	logic [ptts_pkg::MAX_TASKS-1:0] act_q;
	logic [ptts_pkg::MAX_TASKS-1:0] jv_q;

	logic                           accept;
	logic                           we;
	logic [ptts_pkg::SLOT_W-1:0]    waddr;
	ptts_pkg::entry_t               wdata;
	ptts_pkg::entry_t               rdata;
	ptts_pkg::entry_t               upd;
	logic [ptts_pkg::TIME_BITS-1:0] key;
	logic [ptts_pkg::JOB_W-1:0]     jc;
	logic                           hit;
	logic                           upd_act;
	logic                           upd_done;
	logic                           issue_more;

	ptts_task_ram u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (issue_q[ptts_pkg::SLOT_W-1:0]),
		.rdata (rdata)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign key      = (mode == ptts_pkg::MODE_EDF) ? rdata.deadline_left : rdata.period_tab;
	assign hit      = found_q && (idx_s1 == pick_q);
	assign jc       = jv_q[idx_s1] ? rdata.job_count : ptts_pkg::JOB_W'(1);
	assign issue_more = (state_q == ST_SCAN) ? (issue_q < n_live)
		: (issue_q != ptts_pkg::CNT_W'(ptts_pkg::MAX_TASKS));

	// budget spend for the chosen task, then countdown and period reload
	always_comb begin
		upd      = rdata;
		upd_act  = act_q[idx_s1];
		upd_done = 1'b0;
		upd.job_count = jc;
		if (hit) begin
			if (rdata.budget_left != '0) begin
				upd.budget_left = rdata.budget_left - 1'b1;
			end
			upd_done = (upd.budget_left == '0);
			if (upd_done) begin
				upd_act = 1'b0;
				upd.job_count = (jc == '1) ? ptts_pkg::JOB_W'(1) : jc + 1'b1;
			end
		end
		if ({1'b0, idx_s1} < n_live) begin
			upd.deadline_left = rdata.deadline_left - 1'b1;
			if (upd.deadline_left == '0) begin
				upd.deadline_left = rdata.period_tab;
				upd.budget_left   = rdata.budget_tab;
				upd_act           = 1'b1;
			end
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_s1;
		wdata = upd;
		if (accept && func == ptts_pkg::FUNC_LOAD) begin
			we    = 1'b1;
			waddr = slot;
			wdata = '{budget_tab: budget, period_tab: period_len, budget_left: budget,
				deadline_left: period_len, job_count: ptts_pkg::JOB_W'(1)};
		end else if (state_q == ST_CDWN && vld_s1) begin
			we = 1'b1;
		end
	end

	assign res_valid = (state_q == ST_DONE) && out_free;
	always_comb begin
		res.ran_slot   = found_q ? pick_q : '0;
		res.idle       = !found_q;
		res.job_number = found_q ? jobn_q : '0;
		res.job_done   = found_q && done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_q     <= '0;
			vld_s1      <= 1'b0;
			found_q     <= 1'b0;
			cur_valid_q <= 1'b0;
			cur_q       <= '0;
			act_q       <= '0;
			jv_q        <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					vld_s1  <= 1'b0;
					issue_q <= '0;
					if (accept) begin
						if (func == ptts_pkg::FUNC_LOAD) begin
							act_q[slot] <= 1'b1;
							jv_q[slot]  <= 1'b1;
						end else if (mode == ptts_pkg::MODE_RMS && cur_valid_q && act_q[cur_q]) begin
							found_q <= 1'b1;
							pick_q  <= cur_q;
							state_q <= ST_CDWN;
						end else begin
							found_q <= 1'b0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (vld_s1 && act_q[idx_s1] && (!found_q || key < best_q)) begin
						found_q <= 1'b1;
						best_q  <= key;
						pick_q  <= idx_s1;
					end
					vld_s1 <= issue_more;
					idx_s1 <= issue_q[ptts_pkg::SLOT_W-1:0];
					if (issue_more) begin
						issue_q <= issue_q + 1'b1;
					end else if (!vld_s1) begin
						issue_q <= '0;
						state_q <= ST_CDWN;
					end
				end
				ST_CDWN: begin
					if (vld_s1) begin
						act_q[idx_s1] <= upd_act;
						jv_q[idx_s1]  <= 1'b1;
						if (hit) begin
							jobn_q <= jc;
							done_q <= upd_done;
						end
					end
					vld_s1 <= issue_more;
					idx_s1 <= issue_q[ptts_pkg::SLOT_W-1:0];
					if (issue_more) begin
						issue_q <= issue_q + 1'b1;
					end else if (!vld_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						cur_valid_q <= found_q;
						cur_q       <= found_q ? pick_q : '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> src/periodic_task_tick_scheduler.sv
// Tick-driven scheduler for up to 16 periodic tasks, EDF or non-preemptive RMS.
// Input channel (in_valid/in_stall): func selects a load request, which writes
// one task entry (slot, budget, period_len), or a tick request.
// A load writes its task entry and gives no result. A tick gives exactly one result on
// the output channel (out_valid/out_stall): the task that ran, its job number
// and whether the job finished, or idle.
// A tick's result comes from a selection pass reading one table entry per cycle from
// the task memory, then a countdown pass that reads, updates and writes back all 16
// entries one per cycle, then a hand-over of the result, which waits while the
// output register is still full. No new request is taken until the hand-over.
// In RMS mode with a running task still active the selection pass is skipped.
// Config port (cfg_valid/cfg_ready, cfg_index, cfg_data): register 0 sched_mode,
// register 1 task_count; write only when no tick is in flight.
// Reset clears all active marks, sets job counts to one and forgets the current
// task; budget and period contents are undefined until loaded.
// A finished result waits in the output register; a new request is taken while
// it waits, and a tick that finishes then holds until the result is taken.
module periodic_task_tick_scheduler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              func,
	input  logic [ptts_pkg::SLOT_W-1:0]       slot,
	input  logic [ptts_pkg::TIME_BITS-1:0]    budget,
	input  logic [ptts_pkg::TIME_BITS-1:0]    period_len,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ptts_pkg::SLOT_W-1:0]       ran_slot,
	output logic                              idle,
	output logic [ptts_pkg::JOB_W-1:0]        job_number,
	output logic                              job_done,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ptts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ptts_pkg::CFG_W-1:0]        cfg_data
);

	logic                       mode_q;
	logic [ptts_pkg::CFG_W-1:0] task_count_q;
	logic [ptts_pkg::CNT_W-1:0] n_live;
	logic                       out_valid_q;
	logic                       out_free;
	logic                       res_valid;
	ptts_pkg::result_t          res;
	ptts_pkg::result_t          res_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= ptts_pkg::MODE_EDF;
			task_count_q <= ptts_pkg::CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ptts_pkg::REG_SCHED_MODE: mode_q       <= cfg_data[0];
				ptts_pkg::REG_TASK_COUNT: task_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign n_live = (task_count_q > ptts_pkg::CFG_W'(ptts_pkg::MAX_TASKS))
		? ptts_pkg::CNT_W'(ptts_pkg::MAX_TASKS) : ptts_pkg::CNT_W'(task_count_q);

	assign out_free = !out_valid_q || !out_stall;

	ptts_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.slot       (slot),
		.budget     (budget),
		.period_len (period_len),
		.mode       (mode_q),
		.n_live     (n_live),
		.out_free   (out_free),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign ran_slot   = res_q.ran_slot;
	assign idle       = res_q.idle;
	assign job_number = res_q.job_number;
	assign job_done   = res_q.job_done;

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ptts_pkg::*;

	typedef struct packed {
		logic                 func;
		logic [SLOT_W-1:0]    slot;
		logic [TIME_BITS-1:0] budget;
		logic [TIME_BITS-1:0] period_len;
	} sched_req_t;

	typedef enum int {QUIET, SEND_GAPS, RECV_STALLS, BOTH_GAPS} idling_e;

	localparam int GAP_PCT       = 48;
	localparam int BOTH_PCT      = 27;
	localparam int SETTLE_CYCLES = 60;
	localparam int STALL_LIMIT   = 3000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SHOWN_FAULTS  = 40;

	// Task table mirror and the results it owes, oldest first.
	class tick_board;
		logic [TIME_BITS-1:0] bud_tab  [MAX_TASKS];
		logic [TIME_BITS-1:0] per_tab  [MAX_TASKS];
		logic [TIME_BITS-1:0] bud_left [MAX_TASKS];
		logic [TIME_BITS-1:0] dl_left  [MAX_TASKS];
		logic [JOB_W-1:0]     jobs     [MAX_TASKS];
		bit                   active   [MAX_TASKS];
		bit                   cur_ok;
		int                   cur;
		logic                 mode;
		int                   ntasks;
		result_t              owed [$];
		int                   faults;

		function new();
			for (int i = 0; i < MAX_TASKS; i++) begin
				bud_tab[i]  = '0;
				per_tab[i]  = '0;
				bud_left[i] = '0;
				dl_left[i]  = '0;
				jobs[i]     = JOB_W'(1);
				active[i]   = 1'b0;
			end
			cur_ok = 1'b0;
			cur    = 0;
			mode   = MODE_EDF;
			ntasks = 1;
			faults = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
			if (idx == REG_SCHED_MODE)
				mode = val[0];
			else
				ntasks = int'(val);
		endfunction

		function void take_request(sched_req_t r);
			int                   n;
			int                   pick;
			bit                   found;
			logic [TIME_BITS-1:0] key;
			logic [TIME_BITS-1:0] best;
			result_t              res;
			n = (ntasks > MAX_TASKS) ? MAX_TASKS : ntasks;
			if (r.func == FUNC_LOAD) begin
				bud_tab[r.slot]  = r.budget;
				per_tab[r.slot]  = r.period_len;
				bud_left[r.slot] = r.budget;
				dl_left[r.slot]  = r.period_len;
				active[r.slot]   = 1'b1;
				jobs[r.slot]     = JOB_W'(1);
				return;
			end
			found = 1'b0;
			pick  = 0;
			best  = '0;
			// RMS does not preempt: the running task keeps the slot while active
			if (mode == MODE_RMS && cur_ok && active[cur]) begin
				found = 1'b1;
				pick  = cur;
			end else begin
				for (int i = 0; i < n; i++) begin
					if (!active[i])
						continue;
					key = (mode == MODE_EDF) ? dl_left[i] : per_tab[i];
					if (!found || key < best) begin
						found = 1'b1;
						best  = key;
						pick  = i;
					end
				end
			end
			res = '0;
			if (found) begin
				res.ran_slot   = SLOT_W'(pick);
				res.job_number = jobs[pick];
				if (bud_left[pick] != '0)
					bud_left[pick] = bud_left[pick] - 1'b1;
				res.job_done = (bud_left[pick] == '0);
				if (res.job_done) begin
					active[pick] = 1'b0;
					jobs[pick]   = (jobs[pick] == '1) ? JOB_W'(1) : jobs[pick] + 1'b1;
				end
				cur_ok = 1'b1;
				cur    = pick;
			end else begin
				res.idle = 1'b1;
				cur_ok   = 1'b0;
				cur      = 0;
			end
			for (int i = 0; i < n; i++) begin
				dl_left[i] = dl_left[i] - 1'b1;
				if (dl_left[i] == '0) begin
					dl_left[i]  = per_tab[i];
					bud_left[i] = bud_tab[i];
					active[i]   = 1'b1;
				end
			end
			owed.push_back(res);
		endfunction

		task report(string what);
			faults++;
			if (faults <= SHOWN_FAULTS)
				$display("%0t mismatch: %s", $time, what);
		endtask

		task check_result(result_t got);
			result_t want;
			if (owed.size() == 0) begin
				report($sformatf("result with no tick outstanding (slot %0d idle %0b)",
					got.ran_slot, got.idle));
				return;
			end
			want = owed.pop_front();
			if (got.ran_slot !== want.ran_slot)
				report($sformatf("ran_slot %0d, want %0d", got.ran_slot, want.ran_slot));
			if (got.idle !== want.idle)
				report($sformatf("idle %0b, want %0b", got.idle, want.idle));
			if (got.job_number !== want.job_number)
				report($sformatf("job_number %0d, want %0d", got.job_number, want.job_number));
			if (got.job_done !== want.job_done)
				report($sformatf("job_done %0b, want %0b", got.job_done, want.job_done));
		endtask
	endclass

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_stall;
	logic                  func       = FUNC_LOAD;
	logic [SLOT_W-1:0]     slot       = '0;
	logic [TIME_BITS-1:0]  budget     = '0;
	logic [TIME_BITS-1:0]  period_len = '0;
	logic                  out_valid;
	logic                  out_stall  = 1'b0;
	logic [SLOT_W-1:0]     ran_slot;
	logic                  idle;
	logic [JOB_W-1:0]      job_number;
	logic                  job_done;
	logic                  cfg_valid  = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_W-1:0]      cfg_data   = '0;

	idling_e   idling       = QUIET;
	bit        hold_ask     = 1'b0;
	int        hold_left    = 0;
	int        quiet_cycles = 0;
	tick_board board;

	periodic_task_tick_scheduler dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int gap_pct(bit recv_side);
		case (idling)
			BOTH_GAPS:   return BOTH_PCT;
			SEND_GAPS:   return recv_side ? 0 : GAP_PCT;
			RECV_STALLS: return recv_side ? GAP_PCT : 0;
			default:     return 0;
		endcase
	endfunction

	function automatic sched_req_t tick_req();
		sched_req_t r;
		r.func       = FUNC_TICK;
		r.slot       = SLOT_W'($urandom);
		r.budget     = TIME_BITS'($urandom);
		r.period_len = TIME_BITS'($urandom);
		return r;
	endfunction

	function automatic sched_req_t load_req(int s, int b, int p);
		sched_req_t r;
		r.func       = FUNC_LOAD;
		r.slot       = SLOT_W'(s);
		r.budget     = TIME_BITS'(b);
		r.period_len = TIME_BITS'(p);
		return r;
	endfunction

	// mostly ticks; loads are mostly short jobs so that deadlines keep rolling over
	function automatic sched_req_t random_req();
		sched_req_t r;
		int         roll;
		int         b;
		roll = $urandom_range(99);
		b    = $urandom_range(1, 6);
		r    = tick_req();
		if (roll < 72)
			return r;
		r.func = FUNC_LOAD;
		if (roll < 92) begin
			r.budget     = TIME_BITS'(b);
			r.period_len = TIME_BITS'($urandom_range(b, 40));
		end else if (roll < 94) begin
			r.budget     = '0;
			r.period_len = TIME_BITS'($urandom_range(1, 40));
		end else if (roll < 96) begin
			r.budget     = TIME_BITS'(b);
			r.period_len = '0;
		end
		return r;
	endfunction

	task automatic send_req(sched_req_t r);
		int gap;
		gap = 0;
		while ($urandom_range(99) < gap_pct(1'b0))
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= r.func;
		slot       <= r.slot;
		budget     <= r.budget;
		period_len <= r.period_len;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.take_request(r);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (board.owed.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(logic mode, int count);
		logic [CFG_W-1:0] d;
		settle();
		d    = CFG_W'($urandom);
		d[0] = mode;
		cfg_valid <= 1'b1;
		cfg_index <= REG_SCHED_MODE;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.set_reg(REG_SCHED_MODE, d);
		d = CFG_W'(count);
		cfg_index <= REG_TASK_COUNT;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.set_reg(REG_TASK_COUNT, d);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(logic mode, int count, idling_e how, int reqs, bit squeeze);
		write_regs(mode, count);
		idling = how;
		for (int k = 0; k < reqs; k++) begin
			if (squeeze && k == 10)
				hold_ask = 1'b1;
			send_req(random_req());
		end
	endtask

	always @(posedge clk) begin
		if (out_valid && !out_stall)
			board.check_result({ran_slot, idle, job_number, job_done});
		if (hold_ask) begin
			hold_ask  = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < gap_pct(1'b1));
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		board = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// every entry loaded before any tick can reach it
		send_req(load_req(0, 0, 3));
		send_req(load_req(1, 16'hFFFF, 0));
		send_req(load_req(2, 16'hFFFF, 16'hFFFF));
		for (int s = 3; s < MAX_TASKS; s++)
			send_req(load_req(s, 1 + s % 3, 4 + 3 * s));
		repeat (3) send_req(tick_req());
		write_regs(MODE_RMS, 16);
		repeat (3) send_req(tick_req());
		// running task now lies outside the count
		write_regs(MODE_RMS, 0);
		repeat (2) send_req(tick_req());
		write_regs(MODE_EDF, 0);
		send_req(tick_req());

		for (int s = 0; s < MAX_TASKS; s++)
			send_req(load_req(s, $urandom_range(1, 5), $urandom_range(5, 30)));
		run_phase(MODE_EDF, 16, QUIET, 110, 1'b0);
		run_phase(MODE_RMS, 16, SEND_GAPS, 110, 1'b0);
		run_phase(MODE_EDF, 5, RECV_STALLS, 110, 1'b0);
		run_phase(MODE_RMS, 0, BOTH_GAPS, 30, 1'b0);
		run_phase(MODE_EDF, 31, QUIET, 110, 1'b1);
		run_phase(MODE_RMS, 17, BOTH_GAPS, 110, 1'b0);
		run_phase(MODE_EDF, 1, RECV_STALLS, 60, 1'b0);
		run_phase(MODE_RMS, 3, BOTH_GAPS, 70, 1'b0);

		settle();
		if (board.faults == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

>>> sim.f
src/ptts_pkg.sv
src/ptts_task_ram.sv
src/ptts_engine.sv
src/periodic_task_tick_scheduler.sv
tb/sv/tb_top.sv
